// ===== hdl/mme_pkg.sv =====
// shared types, constants and codes for the matrix multiply element block
package mme_pkg;

    localparam int MAX_DIM_DEF    = 16;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int IDX_W      = 4;
    localparam int VALUE_W    = 16;
    localparam int FUNC_W     = 2;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int PRODUCT_W  = 36;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_A = 2'd0,
        FUNC_WRITE_B = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A     = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_B     = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic start;
        logic bad;
        logic write_a;
        logic write_b;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_ok;
        logic nk_zero;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== hdl/mme_ctrl.sv =====
// controller state machine: item decode, dot product sequencing, result hand-off
module mme_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [mme_pkg::FUNC_W-1:0] s_tuser,
    input  mme_pkg::ctrl_status_t  status,
    output mme_pkg::ctrl_cmd_t     cmd
);

    mme_pkg::state_t state_reg;
    mme_pkg::state_t state_next;
    mme_pkg::func_t  func;
    logic            accept;

    assign func     = mme_pkg::func_t'(s_tuser);
    assign s_tready = (state_reg == mme_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mme_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mme_pkg::ST_IDLE: begin
                if (accept) begin
                    case (func)
                        mme_pkg::FUNC_WRITE_A, mme_pkg::FUNC_WRITE_B: begin
                            if (!status.in_ok) begin
                                state_next = mme_pkg::ST_RESULT;
                            end
                        end
                        mme_pkg::FUNC_COMPUTE: begin
                            if (!status.in_ok) begin
                                state_next = mme_pkg::ST_RESULT;
                            end else if (status.nk_zero) begin
                                state_next = mme_pkg::ST_DRAIN;
                            end else begin
                                state_next = mme_pkg::ST_RUN;
                            end
                        end
                        default: state_next = mme_pkg::ST_IDLE;
                    endcase
                end
            end
            mme_pkg::ST_RUN: begin
                if (status.last_issue) begin
                    state_next = mme_pkg::ST_DRAIN;
                end
            end
            mme_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = mme_pkg::ST_RESULT;
                end
            end
            mme_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default: state_next = mme_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            mme_pkg::ST_IDLE: begin
                if (accept) begin
                    case (func)
                        mme_pkg::FUNC_WRITE_A: begin
                            cmd.write_a = status.in_ok;
                            cmd.start   = !status.in_ok;
                            cmd.bad     = !status.in_ok;
                        end
                        mme_pkg::FUNC_WRITE_B: begin
                            cmd.write_b = status.in_ok;
                            cmd.start   = !status.in_ok;
                            cmd.bad     = !status.in_ok;
                        end
                        mme_pkg::FUNC_COMPUTE: begin
                            cmd.start = 1'b1;
                            cmd.bad   = !status.in_ok;
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            mme_pkg::ST_RUN:    cmd.issue    = 1'b1;
            mme_pkg::ST_DRAIN:  cmd          = '0;
            mme_pkg::ST_RESULT: cmd.load_out = status.out_free;
            default:            cmd          = '0;
        endcase
    end

`ifndef SYNTH
    a_result_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mme_pkg::ST_RESULT) |-> !status.pipe_busy)
        else $error("result state entered with products still in flight");

    a_no_write_in_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write_a || cmd.write_b) |-> !status.pipe_busy)
        else $error("store written while a dot product is running");

    a_last_issue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && status.last_issue) |=> (state_reg == mme_pkg::ST_DRAIN))
        else $error("last inner index issued without draining");
`endif

endmodule

// ===== hdl/mme_datapath.sv =====
// datapath: shape registers, element stores, multiply-accumulate and result register
module mme_datapath #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [mme_pkg::FUNC_W-1:0]     s_tuser,
    input  logic [mme_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mme_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,
    input  mme_pkg::ctrl_cmd_t             cmd,
    output mme_pkg::ctrl_status_t          status
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int MUL_W  = 2 * ELEM_WIDTH;

    logic [mme_pkg::CFG_W-1:0] rows_a_reg;
    logic [mme_pkg::CFG_W-1:0] inner_size_reg;
    logic [mme_pkg::CFG_W-1:0] cols_b_reg;

    logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

    logic [mme_pkg::IDX_W-1:0] in_row;
    logic [mme_pkg::IDX_W-1:0] in_col;
    logic signed [mme_pkg::VALUE_W-1:0] in_value;
    logic signed [ELEM_WIDTH-1:0] in_elem;
    logic [AW-1:0] wr_addr;

    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
    logic row_lt_nr, row_lt_nk, col_lt_nk, col_lt_nc;
    logic in_ok;

    logic [mme_pkg::IDX_W-1:0] row_reg;
    logic [mme_pkg::IDX_W-1:0] col_reg;
    logic                      bad_reg;
    logic [KW-1:0]             k_reg;
    logic [AW-1:0]             rd_addr_a;
    logic [AW-1:0]             rd_addr_b;

    logic signed [ELEM_WIDTH-1:0] rd_a_reg;
    logic signed [ELEM_WIDTH-1:0] rd_b_reg;
    logic                         rd_vld_reg;
    logic signed [MUL_W-1:0]      prod_reg;
    logic                         mul_vld_reg;
    logic signed [mme_pkg::PRODUCT_W-1:0] acc_reg;
    logic signed [mme_pkg::PRODUCT_W-1:0] acc_next;

    logic                              out_vld_reg;
    logic [mme_pkg::PRODUCT_W-1:0]     out_product_reg;
    logic                              out_bad_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mme_pkg::CFG_W-1:0] r);
        clamp_dim = (32'(r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg     <= mme_pkg::CFG_W'(1);
            inner_size_reg <= mme_pkg::CFG_W'(1);
            cols_b_reg     <= mme_pkg::CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (mme_pkg::cfg_idx_t'(cfg_index))
                mme_pkg::CFG_ROWS_A:     rows_a_reg     <= cfg_wdata;
                mme_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_wdata;
                mme_pkg::CFG_COLS_B:     cols_b_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_value = s_tdata[23:8];
    assign in_elem  = ELEM_WIDTH'(in_value);
    assign wr_addr  = AW'(32'(in_row) * MAX_DIM + 32'(in_col));

    assign nr = clamp_dim(rows_a_reg);
    assign nk = clamp_dim(inner_size_reg);
    assign nc = clamp_dim(cols_b_reg);

    assign row_lt_nr = 32'(in_row) < 32'(nr);
    assign row_lt_nk = 32'(in_row) < 32'(nk);
    assign col_lt_nk = 32'(in_col) < 32'(nk);
    assign col_lt_nc = 32'(in_col) < 32'(nc);

    always_comb begin
        case (mme_pkg::func_t'(s_tuser))
            mme_pkg::FUNC_WRITE_A: in_ok = row_lt_nr && col_lt_nk;
            mme_pkg::FUNC_WRITE_B: in_ok = row_lt_nk && col_lt_nc;
            mme_pkg::FUNC_COMPUTE: in_ok = row_lt_nr && col_lt_nc;
            default:               in_ok = 1'b0;
        endcase
    end

    assign status.in_ok      = in_ok;
    assign status.nk_zero    = (nk == '0);
    assign status.last_issue = (32'(k_reg) + 32'd1 == 32'(nk));
    assign status.pipe_busy  = rd_vld_reg || mul_vld_reg;
    assign status.out_free   = !out_vld_reg || m_tready;

    assign rd_addr_a = AW'(32'(row_reg) * MAX_DIM + 32'(k_reg));
    assign rd_addr_b = AW'(32'(k_reg) * MAX_DIM + 32'(col_reg));

    // element stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (cmd.write_a) begin
            mem_a[wr_addr] <= in_elem;
        end
        if (cmd.write_b) begin
            mem_b[wr_addr] <= in_elem;
        end
        if (cmd.issue) begin
            rd_a_reg <= mem_a[rd_addr_a];
            rd_b_reg <= mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            row_reg <= in_row;
            col_reg <= in_col;
            bad_reg <= cmd.bad;
        end
        if (rd_vld_reg) begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= cmd.issue;
            mul_vld_reg <= rd_vld_reg;
            if (cmd.start) begin
                k_reg <= '0;
            end else if (cmd.issue) begin
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    assign acc_next = acc_reg + mme_pkg::PRODUCT_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_product_reg <= bad_reg ? '0 : acc_reg;
            out_bad_reg     <= bad_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = mme_pkg::M_TDATA_W'(out_product_reg);
    assign m_tuser  = out_bad_reg;

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && out_vld_reg) |-> m_tready)
        else $error("pending result overwritten");
`endif

endmodule

// ===== hdl/matrix_multiply_element.sv =====
// top level of the matrix multiply element block
//
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  tuser func, tdata row, col, value
// m_        out        m_tvalid / m_tready  tuser bad_index, tdata product
// cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// a load item is written as it is taken; a compute result is loaded after one read per
// inner index, a drain through the read and product registers and the load, or after the
// drain alone with inner_size 0; an out-of-shape result is loaded without reads or drain
// reset is synchronous; the element stores are not cleared and the user must write them
// before reading (not enforced by the block); a finished result sits in the output register
// while the next item is taken, and a later result waits in the controller until it is free
module matrix_multiply_element #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mme_pkg::S_TDATA_W-1:0]  s_tdata,   // row, col, value
    input  logic [mme_pkg::FUNC_W-1:0]     s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mme_pkg::M_TDATA_W-1:0]  m_tdata,   // product, zero pad
    output logic [0:0]                     m_tuser    // bad_index
);

    mme_pkg::ctrl_cmd_t    cmd;
    mme_pkg::ctrl_status_t status;

    mme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    mme_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tb_matrix_multiply_element.sv =====
// self-checking testbench for the matrix multiply element block
module tb_matrix_multiply_element;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mme_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_TARGET = 600;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_CYCLES = 500000;

    typedef struct {
        logic [mme_pkg::PRODUCT_W-1:0] product;
        logic                          bad_index;
    } element_result_t;

    class element_scoreboard;
        logic [mme_pkg::CFG_W-1:0] rows_a;
        logic [mme_pkg::CFG_W-1:0] inner_size;
        logic [mme_pkg::CFG_W-1:0] cols_b;
        logic signed [15:0] a_store [256];
        logic signed [15:0] b_store [256];
        element_result_t    expected_elements [$];
        int                 mismatches;
        int                 results_seen;
        int                 flags_seen;

        function new();
            rows_a = 1;
            inner_size = 1;
            cols_b = 1;
            mismatches = 0;
            results_seen = 0;
            flags_seen = 0;
        endfunction

        function int dim(logic [mme_pkg::CFG_W-1:0] r);
            return (r > mme_pkg::MAX_DIM_DEF) ? mme_pkg::MAX_DIM_DEF : int'(r);
        endfunction

        function void set_reg(mme_pkg::cfg_idx_t idx, logic [mme_pkg::CFG_W-1:0] val);
            case (idx)
                mme_pkg::CFG_ROWS_A:     rows_a = val;
                mme_pkg::CFG_INNER_SIZE: inner_size = val;
                mme_pkg::CFG_COLS_B:     cols_b = val;
                default: ;
            endcase
        endfunction

        function bit in_shape(logic [mme_pkg::FUNC_W-1:0] func, logic [3:0] row,
                              logic [3:0] col);
            case (func)
                mme_pkg::FUNC_WRITE_A:
                    return row < dim(rows_a) && col < dim(inner_size);
                mme_pkg::FUNC_WRITE_B:
                    return row < dim(inner_size) && col < dim(cols_b);
                mme_pkg::FUNC_COMPUTE:
                    return row < dim(rows_a) && col < dim(cols_b);
                default:
                    return 0;
            endcase
        endfunction

        function logic [mme_pkg::PRODUCT_W-1:0] dot_product(logic [3:0] row, logic [3:0] col);
            longint acc;
            acc = 0;
            for (int k = 0; k < dim(inner_size); k++)
                acc += longint'(a_store[row * 16 + k]) * longint'(b_store[k * 16 + col]);
            return acc[mme_pkg::PRODUCT_W-1:0];
        endfunction

        function void take_item(logic [mme_pkg::FUNC_W-1:0] func, logic [3:0] row,
                                logic [3:0] col, logic [15:0] value);
            element_result_t res;
            if (func == FUNC_UNUSED)
                return;
            res.product = '0;
            res.bad_index = 1'b1;
            if (in_shape(func, row, col)) begin
                if (func == mme_pkg::FUNC_WRITE_A) begin
                    a_store[{row, col}] = value;
                    return;
                end
                if (func == mme_pkg::FUNC_WRITE_B) begin
                    b_store[{row, col}] = value;
                    return;
                end
                res.product = dot_product(row, col);
                res.bad_index = 1'b0;
            end
            expected_elements.push_back(res);
        endfunction

        function void check_element(logic [mme_pkg::PRODUCT_W-1:0] product, logic bad_index);
            element_result_t want;
            results_seen++;
            if (bad_index)
                flags_seen++;
            if (expected_elements.size() == 0) begin
                $display("%0t unexpected item: expected none actual product %h bad_index %b",
                         $time, product, bad_index);
                mismatches++;
                return;
            end
            want = expected_elements.pop_front();
            if (product !== want.product) begin
                $display("%0t product mismatch: expected %h actual %h", $time,
                         want.product, product);
                mismatches++;
            end
            if (bad_index !== want.bad_index) begin
                $display("%0t bad_index mismatch: expected %b actual %b", $time,
                         want.bad_index, bad_index);
                mismatches++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mme_pkg::CFG_W-1:0]      cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mme_pkg::S_TDATA_W-1:0]  s_tdata;   // row, col, value
    logic [mme_pkg::FUNC_W-1:0]     s_tuser;   // func
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mme_pkg::M_TDATA_W-1:0]  m_tdata;   // product, zero pad
    logic [0:0]                     m_tuser;   // bad_index

    element_scoreboard sb;
    bit  a_written [256];
    bit  b_written [256];
    int  item_count;
    int  shape_count;
    int  cycle_count;
    int  idle_pct;
    int  sink_idle_pct;
    bit  hold_req;

    matrix_multiply_element dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_matrix_multiply_element: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_element(m_tdata[mme_pkg::PRODUCT_W-1:0], m_tuser[0]);
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_taken = 1'b1;
            end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [mme_pkg::FUNC_W-1:0] func, logic [3:0] row,
                             logic [3:0] col, logic [15:0] value);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {value, col, row};
        do @(posedge aclk); while (!s_tready);
        if (sb.in_shape(func, row, col)) begin
            if (func == mme_pkg::FUNC_WRITE_A)
                a_written[{row, col}] = 1'b1;
            if (func == mme_pkg::FUNC_WRITE_B)
                b_written[{row, col}] = 1'b1;
        end
        sb.take_item(func, row, col, value);
        if (func != FUNC_UNUSED)
            item_count++;
    endtask

    // for an in-shape element, loads any element of its row and column that was never written, then computes
    task automatic compute_element(logic [3:0] row, logic [3:0] col, logic [15:0] value);
        if (sb.in_shape(mme_pkg::FUNC_COMPUTE, row, col)) begin
            for (int k = 0; k < sb.dim(sb.inner_size); k++) begin
                if (!a_written[row * 16 + k])
                    send_item(mme_pkg::FUNC_WRITE_A, row, 4'(k), pick_value());
                if (!b_written[k * 16 + col])
                    send_item(mme_pkg::FUNC_WRITE_B, 4'(k), col, pick_value());
            end
        end
        send_item(mme_pkg::FUNC_COMPUTE, row, col, value);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_elements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_shape(logic [mme_pkg::CFG_W-1:0] r, logic [mme_pkg::CFG_W-1:0] k,
                             logic [mme_pkg::CFG_W-1:0] c);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= mme_pkg::CFG_ROWS_A;
        cfg_wdata <= r;
        @(posedge aclk);
        sb.set_reg(mme_pkg::CFG_ROWS_A, r);
        cfg_index <= mme_pkg::CFG_INNER_SIZE;
        cfg_wdata <= k;
        @(posedge aclk);
        sb.set_reg(mme_pkg::CFG_INNER_SIZE, k);
        cfg_index <= mme_pkg::CFG_COLS_B;
        cfg_wdata <= c;
        @(posedge aclk);
        sb.set_reg(mme_pkg::CFG_COLS_B, c);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        shape_count++;
    endtask

    task automatic random_item();
        int kind;
        int nr;
        int nk;
        int nc;
        kind = $urandom_range(0, 99);
        nr = sb.dim(sb.rows_a);
        nk = sb.dim(sb.inner_size);
        nc = sb.dim(sb.cols_b);
        if (kind < 55 && nr > 0 && nc > 0)
            compute_element(4'($urandom_range(0, nr - 1)), 4'($urandom_range(0, nc - 1)),
                            16'($urandom));
        else if (kind < 75 && nk > 0 && nr > 0 && nc > 0) begin
            if ($urandom_range(0, 1))
                send_item(mme_pkg::FUNC_WRITE_A, 4'($urandom_range(0, nr - 1)),
                          4'($urandom_range(0, nk - 1)), pick_value());
            else
                send_item(mme_pkg::FUNC_WRITE_B, 4'($urandom_range(0, nk - 1)),
                          4'($urandom_range(0, nc - 1)), pick_value());
        end else if (kind < 90)
            send_item($urandom_range(0, 1) ? mme_pkg::FUNC_WRITE_B : mme_pkg::FUNC_WRITE_A,
                      4'($urandom), 4'($urandom), pick_value());
        else if (kind < 95)
            send_item(FUNC_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
        else
            compute_element(4'($urandom), 4'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [mme_pkg::CFG_W-1:0] shape_list [6][3];
        logic [mme_pkg::CFG_W-1:0] r;
        logic [mme_pkg::CFG_W-1:0] k;
        logic [mme_pkg::CFG_W-1:0] c;
        int                        phase;
        int                        phase_len;
        bit                        hold_done;

        shape_list = '{'{16, 16, 16}, '{31, 20, 17}, '{0, 3, 3}, '{3, 0, 5},
                       '{1, 16, 1}, '{16, 1, 16}};
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = mme_pkg::CFG_ROWS_A;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mme_pkg::FUNC_WRITE_A;
        item_count = 0;
        shape_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        sink_idle_pct = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset shape of one element each
        send_item(mme_pkg::FUNC_WRITE_A, 4'd0, 4'd0, 16'h7fff);
        send_item(mme_pkg::FUNC_WRITE_B, 4'd0, 4'd0, 16'h8000);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd0, 4'd0, 16'hffff);
        send_item(mme_pkg::FUNC_WRITE_A, 4'd15, 4'd15, 16'h1234);
        send_item(mme_pkg::FUNC_WRITE_B, 4'd15, 4'd0, 16'h8000);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd15, 4'd15, 16'h0000);
        send_item(FUNC_UNUSED, 4'd15, 4'd15, 16'hffff);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd0, 4'd15, 16'h0000);
        // largest magnitude product at the far corner
        set_shape(16, 1, 16);
        send_item(mme_pkg::FUNC_WRITE_A, 4'd15, 4'd0, 16'h8000);
        send_item(mme_pkg::FUNC_WRITE_B, 4'd0, 4'd15, 16'h8000);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd15, 4'd15, 16'h0000);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd0, 4'd15, 16'h5a5a);
        // zero-sized shape rejects everything
        set_shape(0, 0, 0);
        send_item(mme_pkg::FUNC_WRITE_A, 4'd0, 4'd0, 16'h0001);
        send_item(mme_pkg::FUNC_WRITE_B, 4'd0, 4'd0, 16'h0001);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
        // empty inner dimension gives a zero sum
        set_shape(2, 0, 2);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd1, 4'd1, 16'h0000);
        send_item(mme_pkg::FUNC_WRITE_A, 4'd1, 4'd0, 16'h0001);
        // register values above the maximum act as the maximum
        set_shape(31, 2, 31);
        compute_element(4'd15, 4'd15, 16'h0000);
        send_item(mme_pkg::FUNC_WRITE_B, 4'd1, 4'd15, 16'h7fff);
        send_item(mme_pkg::FUNC_COMPUTE, 4'd15, 4'd15, 16'h0000);

        phase = 0;
        while (item_count < ITEMS_TARGET) begin
            if (phase < 6) begin
                r = shape_list[phase][0];
                k = shape_list[phase][1];
                c = shape_list[phase][2];
            end else begin
                r = 5'($urandom_range(0, 19));
                k = 5'($urandom_range(0, 19));
                c = 5'($urandom_range(0, 19));
                if (r > 16) r = 5'($urandom_range(17, 31));
                if (k > 16) k = 5'($urandom_range(17, 31));
                if (c > 16) c = 5'($urandom_range(17, 31));
            end
            set_shape(r, k, c);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            sink_idle_pct = $urandom_range(0, 2) * 20;
            phase_len = $urandom_range(40, 90);
            for (int i = 0; i < phase_len && item_count < ITEMS_TARGET; i++) begin
                if (item_count >= ITEMS_TARGET - 120) begin
                    idle_pct = 0;
                    sink_idle_pct = 0;
                end
                if (!hold_done && item_count >= 150) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                random_item();
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.expected_elements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d items over %0d shapes, %0d results checked (%0d error flags)",
                 item_count, shape_count, sb.results_seen, sb.flags_seen);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_matrix_multiply_element: PASS");
        else
            $display("tb_matrix_multiply_element: FAIL");
        $finish;
    end

endmodule

// ===== matrix_multiply_element.f =====
hdl/mme_pkg.sv
hdl/mme_ctrl.sv
hdl/mme_datapath.sv
hdl/matrix_multiply_element.sv
tb/tb_matrix_multiply_element.sv
